@@ hw/rtl/assert_macros.svh @@
// assertion helpers included by pixel_crc32_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("%m: property failed");

`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

@@ hw/rtl/pcrc_pkg.sv @@
package pcrc_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // pixel format codes, unused codes fold all four bytes
  localparam logic [2:0] FmtPix8  = 3'd1;
  localparam logic [2:0] FmtPix16 = 3'd2;
  localparam logic [2:0] FmtPix24 = 3'd3;
  localparam logic [2:0] FmtPix32 = 3'd4;

  typedef logic [31:0] crc_t;

  typedef struct packed {
    logic load;
    crc_t crc;
  } out_load_t;

  // one reflected byte step, xor network after unrolling
  function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] data);
    crc_t c;
    c = crc ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/pcrc_fold.sv @@
module pcrc_fold
  import pcrc_pkg::*;
(
  input  crc_t        crc_in,
  input  logic [31:0] word,
  input  logic [2:0]  fmt,
  output crc_t        crc_out
);

  crc_t s1, s2, s3, s4;

  // byte lanes chained, least significant byte first
  assign s1 = crc_byte(crc_in, word[7:0]);
  assign s2 = crc_byte(s1, word[15:8]);
  assign s3 = crc_byte(s2, word[23:16]);
  assign s4 = crc_byte(s3, word[31:24]);

  always_comb begin
    case (fmt)
      FmtPix8:  crc_out = s1;
      FmtPix16: crc_out = s2;
      FmtPix24: crc_out = s3;
      FmtPix32: crc_out = s4;
      default:  crc_out = s4;
    endcase
  end

endmodule

@@ hw/rtl/pcrc_out_stage.sv @@
module pcrc_out_stage
  import pcrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  out_load_t ld,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output crc_t      out_crc_value
);

  logic out_valid_r, out_valid_nxt;
  crc_t crc_r;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      crc_r <= ld.crc;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = crc_r;

endmodule

@@ hw/rtl/pixel_crc32_engine.sv @@
// Reflected CRC-32 (poly 0xEDB88320) over a pixel stream. One pixel word is
// taken per transfer and its low 1, 2, 3 or 4 bytes (per cfg_pixel_format,
// other codes mean 4) are folded in least significant byte first. A pixel
// with first set restarts from all ones; a pixel with last set delivers the
// inverted CRC on out_crc_value and the next image starts clean. The block
// sustains one pixel per clock unless a last pixel is held. The whole fold
// is one combinational xor network between the input register and the CRC
// register; out_valid is registered in the output stage after the last pixel
// leaves the input register. A last pixel is held there only while an
// earlier result still waits on out_ready. Write cfg only while idle.
`include "assert_macros.svh"

module pixel_crc32_engine
  import pcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_pixel_format,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pixel_word,
  input  logic        in_first_pixel,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_crc_value
);

  logic [2:0]  fmt_r;
  logic        vld_r, vld_nxt;
  logic [31:0] pix_r;
  logic        first_r, last_r;
  crc_t        crc_r, crc_nxt;
  crc_t        crc_base, crc_fold;
  logic        can_load, adv;
  out_load_t   ld;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FmtPix32;
    end else if (cfg_valid && cfg_ready) begin
      fmt_r <= cfg_pixel_format;
    end
  end

  // a non-last pixel never waits on the result side
  assign adv      = vld_r && (!last_r || can_load);
  assign in_ready = !vld_r || adv;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix_r   <= in_pixel_word;
      first_r <= in_first_pixel;
      last_r  <= in_last_pixel;
    end
  end

  assign crc_base = first_r ? CrcInit : crc_r;

  pcrc_fold u_fold (
    .crc_in  (crc_base),
    .word    (pix_r),
    .fmt     (fmt_r),
    .crc_out (crc_fold)
  );

  always_comb begin
    crc_nxt = crc_r;
    if (adv) begin
      crc_nxt = last_r ? CrcInit : crc_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CrcInit;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign ld.load = adv && last_r;
  assign ld.crc  = ~crc_fold;

  pcrc_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .ld            (ld),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_crc_value (out_crc_value)
  );

  `ASSERT_PROP(a_crc_restart, clk, rst_n, (adv && last_r) |=> (crc_r == CrcInit))
  `ASSERT_NEVER(a_last_overrun, clk, rst_n, vld_r && last_r && out_valid && !out_ready && in_ready)
  `ASSERT_PROP(a_cfg_taken, clk, rst_n, (cfg_valid && cfg_ready) |=> (fmt_r == $past(cfg_pixel_format)))
  `ASSERT_PROP(a_result_follows, clk, rst_n, (adv && last_r) |=> out_valid)

endmodule
